// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/ipfr_pkg.sv =====
package ipfr_pkg;

    localparam int DEF_SLOTS         = 16;
    localparam int DEF_PAYLOAD_UNITS = 8192;

    localparam logic [31:0] TIMEOUT_RESET  = 32'd60000;
    localparam logic [15:0] PAYLOAD_RESET  = 16'd65515;
    localparam logic [15:0] DATAGRAM_RESET = 16'd65535;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD  = 2'd1;
    localparam logic [1:0] CFG_DATAGRAM = 2'd2;

    localparam logic [1:0] CMD_FRAGMENT = 2'd0;
    localparam logic [1:0] CMD_EXPIRE   = 2'd1;
    localparam logic [1:0] CMD_DISCARD  = 2'd2;

    localparam logic [2:0] ST_NOT_FRAGMENT = 3'd0;
    localparam logic [2:0] ST_MALFORMED    = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED    = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE   = 3'd3;
    localparam logic [2:0] ST_COMPLETE     = 3'd4;
    localparam logic [2:0] ST_EXPIRED      = 3'd5;
    localparam logic [2:0] ST_NONE_EXPIRED = 3'd6;
    localparam logic [2:0] ST_DISCARDED    = 3'd7;

    localparam int WORD_BITS = 32;
    localparam int UNIT_W    = 14;

    typedef struct packed {
        logic [31:0] source;
        logic [31:0] destination;
        logic [7:0]  protocol;
        logic [15:0] ident;
        logic [31:0] deadline;
    } key_t;

endpackage

// ===== design/ipv4_fragment_reassembly_tracker_top.sv =====
// Tracks IPv4 fragment reassembly over SLOTS slots, one command word at a time. Slot keys and
// deadlines sit in a small RAM searched one slot at a time, a read state then a compare state
// per slot; unit coverage sits in a second RAM of 32-bit words, PAYLOAD_UNITS/32 words per slot.
// A fragment goes through the key search, then a clear of the slot's words when a new slot is
// claimed, then a read and a write for each word it marks, then, once first and last are held,
// a read and a test for each word checked.
// Expire searches the slots in order and frees the first whose deadline has been reached; discard
// frees all slots at once. No clearing pass is needed after reset.
`include "assert_macros.svh"

module ipv4_fragment_reassembly_tracker_top #(
    parameter int SLOTS         = ipfr_pkg::DEF_SLOTS,
    parameter int PAYLOAD_UNITS = ipfr_pkg::DEF_PAYLOAD_UNITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_now,
    input  logic        s_header_valid,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_destination_address,
    input  logic [7:0]  s_protocol_number,
    input  logic [15:0] s_datagram_id,
    input  logic [12:0] s_offset_units,
    input  logic        s_more_fragments,
    input  logic [5:0]  s_ip_header_length,
    input  logic [15:0] s_data_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot_index,
    output logic        m_had_first,
    output logic [15:0] m_datagram_length,
    output logic [5:0]  m_first_header_length
);
    import ipfr_pkg::*;

    localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORDS = (PAYLOAD_UNITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int KEYW  = $bits(key_t);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_SRCH_RD   = 4'd2;
    localparam logic [3:0] S_SRCH_CMP  = 4'd3;
    localparam logic [3:0] S_CLEAR     = 4'd4;
    localparam logic [3:0] S_MARK_RD   = 4'd5;
    localparam logic [3:0] S_MARK_WR   = 4'd6;
    localparam logic [3:0] S_FLAGS     = 4'd7;
    localparam logic [3:0] S_CHK_START = 4'd8;
    localparam logic [3:0] S_CHK_RD    = 4'd9;
    localparam logic [3:0] S_CHK_TEST  = 4'd10;
    localparam logic [3:0] S_EXP_RD    = 4'd11;
    localparam logic [3:0] S_EXP_CMP   = 4'd12;
    localparam logic [3:0] S_EMIT      = 4'd13;

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
    localparam logic [WAW-1:0]  LAST_WORD = WAW'(WORDS - 1);

    logic [3:0] state_reg, state_next;
    logic [IDXW-1:0] idx_reg, idx_next, free_idx_reg, free_idx_next, slot_reg, slot_next;
    logic free_found_reg, free_found_next;
    logic [WAW-1:0] word_reg, word_next, word_last_reg, word_last_next;
    logic [4:0] last_bit_reg, last_bit_next;

    logic [31:0] timeout_reg;
    logic [15:0] payload_limit_reg, datagram_limit_reg;

    logic [SLOTS-1:0] occupied_reg, occupied_next;
    logic [SLOTS-1:0] have_first_reg, have_first_next;
    logic [SLOTS-1:0] have_last_reg, have_last_next;
    logic [15:0] end_size_arr [SLOTS];
    logic [5:0]  first_hlen_arr [SLOTS];

    logic [1:0]  cmd_reg;
    logic [31:0] now_reg, src_reg, dst_reg;
    logic        hv_reg, mf_reg;
    logic [7:0]  proto_reg;
    logic [15:0] id_reg, dlen_reg;
    logic [12:0] off_reg;
    logic [5:0]  hlen_reg;

    logic [2:0]  res_status_reg, res_status_next;
    logic [3:0]  res_slot_reg, res_slot_next;
    logic        res_first_reg, res_first_next;
    logic [15:0] res_dlen_reg, res_dlen_next;
    logic [5:0]  res_hlen_reg, res_hlen_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg;
    logic [3:0]  m_slot_reg;
    logic        m_first_reg;
    logic [15:0] m_dlen_reg;
    logic [5:0]  m_hlen_reg;
    logic        load_out;

    logic            key_we;
    logic [IDXW-1:0] key_waddr;
    key_t            key_wdata, key_rdata;
    logic [KEYW-1:0] key_rbits;

    logic                unit_we;
    logic [WORD_BITS-1:0] unit_wdata, unit_rdata;
    logic [IDXW+WAW-1:0] unit_addr;

    logic [16:0] end_oct, end_round, need_round, total;
    logic [UNIT_W-1:0] end_units, last_unit, need_units, need_last;
    logic [32:0] dl_sum;
    logic [31:0] deadline;
    logic [UNIT_W-1:0] first_word_full, last_word_full, need_word_full;
    logic [4:0] lo_bit, hi_bit;
    logic [WORD_BITS-1:0] mark_mask, req_mask;
    logic key_match, hf_new, hl_new;
    logic [IDXW+3:0] slot_ext, idx_ext;

    assign s_ready = (state_reg == S_IDLE);

    // fragment geometry
    assign end_oct    = {1'b0, off_reg, 3'b000} + {1'b0, dlen_reg};
    assign end_round  = end_oct + 17'd7;
    assign end_units  = end_round[16:3];
    assign last_unit  = end_units - UNIT_W'(1);
    assign first_word_full = UNIT_W'(off_reg >> 5);
    assign last_word_full  = last_unit >> 5;
    assign need_round = {1'b0, end_size_arr[slot_reg]} + 17'd7;
    assign need_units = need_round[16:3];
    assign need_last  = need_units - UNIT_W'(1);
    assign need_word_full = need_last >> 5;
    assign total = {11'd0, first_hlen_arr[slot_reg]} + {1'b0, end_size_arr[slot_reg]};

    assign dl_sum   = {1'b0, now_reg} + {1'b0, timeout_reg};
    assign deadline = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

    assign lo_bit = (word_reg == first_word_full[WAW-1:0]) ? off_reg[4:0] : 5'd0;
    assign hi_bit = (word_reg == word_last_reg) ? last_bit_reg : 5'd31;
    assign mark_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (5'd31 - hi_bit));
    assign req_mask  = (word_reg == word_last_reg) ?
                       ({WORD_BITS{1'b1}} >> (5'd31 - last_bit_reg)) : {WORD_BITS{1'b1}};

    assign key_rdata = key_t'(key_rbits);
    assign key_match = (key_rdata.source == src_reg) && (key_rdata.destination == dst_reg)
                    && (key_rdata.protocol == proto_reg) && (key_rdata.ident == id_reg);
    assign hf_new = have_first_reg[slot_reg] || (off_reg == 13'd0);
    assign hl_new = have_last_reg[slot_reg] || !mf_reg;

    assign slot_ext = {4'd0, slot_reg};
    assign idx_ext  = {4'd0, idx_reg};
    assign unit_addr = {slot_reg, word_reg};
    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        word_next       = word_reg;
        word_last_next  = word_last_reg;
        last_bit_next   = last_bit_reg;
        occupied_next   = occupied_reg;
        have_first_next = have_first_reg;
        have_last_next  = have_last_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_first_next  = res_first_reg;
        res_dlen_next   = res_dlen_reg;
        res_hlen_next   = res_hlen_reg;
        key_we     = 1'b0;
        key_waddr  = idx_reg;
        key_wdata  = '{source: src_reg, destination: dst_reg, protocol: proto_reg,
                       ident: id_reg, deadline: deadline};
        unit_we    = 1'b0;
        unit_wdata = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_status_next = ST_MALFORMED;
                res_slot_next   = 4'd0;
                res_first_next  = 1'b0;
                res_dlen_next   = 16'd0;
                res_hlen_next   = 6'd0;
                idx_next        = '0;
                free_found_next = 1'b0;
                word_last_next  = last_word_full[WAW-1:0];
                last_bit_next   = last_unit[4:0];
                case (cmd_reg)
                    CMD_FRAGMENT: begin
                        if (!hv_reg || hlen_reg < 6'd20 || hlen_reg > 6'd60) begin
                            state_next = S_EMIT;
                        end else if (off_reg == 13'd0 && !mf_reg) begin
                            res_status_next = ST_NOT_FRAGMENT;
                            state_next      = S_EMIT;
                        end else if (dlen_reg == 16'd0 || (mf_reg && dlen_reg[2:0] != 3'd0)
                                     || end_oct > {1'b0, payload_limit_reg}
                                     || end_units > UNIT_W'(PAYLOAD_UNITS)) begin
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    CMD_EXPIRE: begin
                        state_next = S_EXP_RD;
                    end
                    CMD_DISCARD: begin
                        occupied_next   = '0;
                        have_first_next = '0;
                        have_last_next  = '0;
                        res_status_next = ST_DISCARDED;
                        state_next      = S_EMIT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SRCH_RD: begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (occupied_reg[idx_reg] && key_match) begin
                    slot_next  = idx_reg;
                    word_next  = first_word_full[WAW-1:0];
                    state_next = S_MARK_RD;
                end else if (idx_reg == LAST_IDX) begin
                    if (free_found_reg || !occupied_reg[idx_reg]) begin
                        // claim the lowest free slot, its words are cleared before marking
                        key_waddr = free_found_reg ? free_idx_reg : idx_reg;
                        key_we    = 1'b1;
                        slot_next = key_waddr;
                        occupied_next[key_waddr]   = 1'b1;
                        have_first_next[key_waddr] = 1'b0;
                        have_last_next[key_waddr]  = 1'b0;
                        word_next  = '0;
                        state_next = S_CLEAR;
                    end else begin
                        res_status_next = ST_EXHAUSTED;
                        state_next      = S_EMIT;
                    end
                end else begin
                    if (!occupied_reg[idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next   = idx_reg + IDXW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_CLEAR: begin
                unit_we = 1'b1;
                if (word_reg == LAST_WORD) begin
                    word_next  = first_word_full[WAW-1:0];
                    state_next = S_MARK_RD;
                end else begin
                    word_next = word_reg + WAW'(1);
                end
            end
            S_MARK_RD: begin
                state_next = S_MARK_WR;
            end
            S_MARK_WR: begin
                unit_we    = 1'b1;
                unit_wdata = unit_rdata | mark_mask;
                if (word_reg == word_last_reg) begin
                    state_next = S_FLAGS;
                end else begin
                    word_next  = word_reg + WAW'(1);
                    state_next = S_MARK_RD;
                end
            end
            S_FLAGS: begin
                have_first_next[slot_reg] = hf_new;
                have_last_next[slot_reg]  = hl_new;
                if (hf_new && hl_new) begin
                    state_next = S_CHK_START;
                end else begin
                    res_status_next = ST_INCOMPLETE;
                    res_slot_next   = slot_ext[3:0];
                    state_next      = S_EMIT;
                end
            end
            S_CHK_START: begin
                word_next      = '0;
                word_last_next = need_word_full[WAW-1:0];
                last_bit_next  = need_last[4:0];
                state_next     = S_CHK_RD;
            end
            S_CHK_RD: begin
                state_next = S_CHK_TEST;
            end
            S_CHK_TEST: begin
                if ((unit_rdata & req_mask) != req_mask) begin
                    res_status_next = ST_INCOMPLETE;
                    res_slot_next   = slot_ext[3:0];
                    state_next      = S_EMIT;
                end else if (word_reg == word_last_reg) begin
                    occupied_next[slot_reg]   = 1'b0;
                    have_first_next[slot_reg] = 1'b0;
                    have_last_next[slot_reg]  = 1'b0;
                    if (total <= {1'b0, datagram_limit_reg}) begin
                        res_status_next = ST_COMPLETE;
                        res_slot_next   = slot_ext[3:0];
                        res_dlen_next   = total[15:0];
                        res_hlen_next   = first_hlen_arr[slot_reg];
                    end
                    state_next = S_EMIT;
                end else begin
                    word_next  = word_reg + WAW'(1);
                    state_next = S_CHK_RD;
                end
            end
            S_EXP_RD: begin
                state_next = S_EXP_CMP;
            end
            S_EXP_CMP: begin
                if (occupied_reg[idx_reg] && key_rdata.deadline <= now_reg) begin
                    occupied_next[idx_reg]   = 1'b0;
                    have_first_next[idx_reg] = 1'b0;
                    have_last_next[idx_reg]  = 1'b0;
                    res_status_next = ST_EXPIRED;
                    res_slot_next   = idx_ext[3:0];
                    res_first_next  = have_first_reg[idx_reg];
                    state_next      = S_EMIT;
                end else if (idx_reg == LAST_IDX) begin
                    res_status_next = ST_NONE_EXPIRED;
                    state_next      = S_EMIT;
                end else begin
                    idx_next   = idx_reg + IDXW'(1);
                    state_next = S_EXP_RD;
                end
            end
            S_EMIT: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            occupied_reg       <= '0;
            have_first_reg     <= '0;
            have_last_reg      <= '0;
            m_valid_reg        <= 1'b0;
            timeout_reg        <= TIMEOUT_RESET;
            payload_limit_reg  <= PAYLOAD_RESET;
            datagram_limit_reg <= DATAGRAM_RESET;
        end else begin
            state_reg      <= state_next;
            occupied_reg   <= occupied_next;
            have_first_reg <= have_first_next;
            have_last_reg  <= have_last_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_write) begin
                case (cfg_index)
                    CFG_TIMEOUT:  timeout_reg        <= cfg_data;
                    CFG_PAYLOAD:  payload_limit_reg  <= cfg_data[15:0];
                    CFG_DATAGRAM: datagram_limit_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        slot_reg       <= slot_next;
        word_reg       <= word_next;
        word_last_reg  <= word_last_next;
        last_bit_reg   <= last_bit_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_first_reg  <= res_first_next;
        res_dlen_reg   <= res_dlen_next;
        res_hlen_reg   <= res_hlen_next;
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            now_reg   <= s_now;
            hv_reg    <= s_header_valid;
            src_reg   <= s_source_address;
            dst_reg   <= s_destination_address;
            proto_reg <= s_protocol_number;
            id_reg    <= s_datagram_id;
            off_reg   <= s_offset_units;
            mf_reg    <= s_more_fragments;
            hlen_reg  <= s_ip_header_length;
            dlen_reg  <= s_data_length;
        end
        if (state_reg == S_FLAGS) begin
            if (off_reg == 13'd0) begin
                first_hlen_arr[slot_reg] <= hlen_reg;
            end
            if (!mf_reg) begin
                end_size_arr[slot_reg] <= end_oct[15:0];
            end
        end
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_first_reg  <= res_first_reg;
            m_dlen_reg   <= res_dlen_reg;
            m_hlen_reg   <= res_hlen_reg;
        end
    end

    ipfr_ram #(
        .WIDTH(KEYW),
        .DEPTH(1 << IDXW)
    ) u_key_ram (
        .aclk (aclk),
        .we   (key_we),
        .waddr(key_waddr),
        .wdata(KEYW'(key_wdata)),
        .raddr(idx_reg),
        .rdata(key_rbits)
    );

    // coverage words, one row of words per slot
    ipfr_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(1 << (IDXW + WAW))
    ) u_unit_ram (
        .aclk (aclk),
        .we   (unit_we),
        .waddr(unit_addr),
        .wdata(unit_wdata),
        .raddr(unit_addr),
        .rdata(unit_rdata)
    );

    assign m_valid               = m_valid_reg;
    assign m_status              = m_status_reg;
    assign m_slot_index          = m_slot_reg;
    assign m_had_first           = m_first_reg;
    assign m_datagram_length     = m_dlen_reg;
    assign m_first_header_length = m_hlen_reg;

    `ASSERT_ALWAYS(a_reset_idle, !aresetn |=> state_reg == S_IDLE, "not idle after reset")
    `ASSERT_CLK(a_unit_owned, unit_we |-> occupied_reg[slot_reg], "unit write to free slot")
    `ASSERT_CLK(a_key_free, key_we |-> !occupied_reg[key_waddr], "key written over held slot")
    `ASSERT_CLK(a_out_held, (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_status_reg)),
                "pending result overwritten")

endmodule

// ===== design/ipfr_ram.sv =====
module ipfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
